// ----- hw/rtl/i2cbf_pkg.sv -----
// i2cbf_pkg: shared types and constants of the i2c target byte fifos block
// beat structs, event codes and ring sizes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2cbf_pkg;

  localparam int RX_DEPTH = 8;
  localparam int TX_DEPTH = 8;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);

  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 3;

  typedef enum logic [2:0] {
    MODE_ADDR_CHECK = 3'd0,
    MODE_BUS_READ   = 3'd1,
    MODE_BUS_WRITE  = 3'd2,
    MODE_HOST_PUSH  = 3'd3,
    MODE_HOST_POP   = 3'd4,
    MODE_FLUSH      = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [ADDR_W-1:0]   bus_address;
    logic                is_write;
    logic [BYTE_W-1:0]   data_in;
    logic                flush_rx;
    logic                flush_tx;
  } in_item_t;

  typedef struct packed {
    logic                addr_match;
    logic                addr_dir_write;
    logic [BYTE_W-1:0]   data_out;
    logic [COUNT_W-1:0]  rx_count;
    logic                rx_empty;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/i2cbf_core.sv -----
// i2cbf_core: ring state and per-event logic of the i2c target byte fifos
// uses i2cbf_pkg; result is combinational, state commits when fire is high
`timescale 1ns / 1ps
`default_nettype none

module i2cbf_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire i2cbf_pkg::in_item_t           item,
  input  wire logic [i2cbf_pkg::ADDR_W-1:0]  own_address,
  output i2cbf_pkg::out_item_t               result
);

  localparam logic [i2cbf_pkg::RX_PTR_W-1:0] RX_LAST =
    i2cbf_pkg::RX_PTR_W'(i2cbf_pkg::RX_DEPTH - 1);
  localparam logic [i2cbf_pkg::TX_PTR_W-1:0] TX_LAST =
    i2cbf_pkg::TX_PTR_W'(i2cbf_pkg::TX_DEPTH - 1);
  localparam logic [i2cbf_pkg::RX_PTR_W:0] RX_DEPTH_X =
    (i2cbf_pkg::RX_PTR_W + 1)'(i2cbf_pkg::RX_DEPTH);

  logic [i2cbf_pkg::BYTE_W-1:0]   rx_store_r [i2cbf_pkg::RX_DEPTH];
  logic [i2cbf_pkg::BYTE_W-1:0]   tx_store_r [i2cbf_pkg::TX_DEPTH];
  logic [i2cbf_pkg::RX_PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [i2cbf_pkg::TX_PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [i2cbf_pkg::RX_PTR_W-1:0] rx_head_inc, rx_tail_inc;
  logic [i2cbf_pkg::TX_PTR_W-1:0] tx_head_inc, tx_tail_inc;
  logic [i2cbf_pkg::RX_PTR_W:0]   rx_fill;
  logic                           rx_wr, tx_wr;

  // wrapping increments
  assign rx_head_inc = (rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_inc = (tx_head_r == TX_LAST) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TX_LAST) ? '0 : tx_tail_r + 1'b1;

  always_comb begin
    rx_head_nxt           = rx_head_r;
    rx_tail_nxt           = rx_tail_r;
    tx_head_nxt           = tx_head_r;
    tx_tail_nxt           = tx_tail_r;
    rx_wr                 = 1'b0;
    tx_wr                 = 1'b0;
    result.addr_match     = 1'b0;
    result.addr_dir_write = 1'b0;
    result.data_out       = '0;
    case (item.mode)
      i2cbf_pkg::MODE_ADDR_CHECK: begin
        if (item.bus_address == own_address) begin
          result.addr_match     = 1'b1;
          result.addr_dir_write = item.is_write;
        end
      end
      i2cbf_pkg::MODE_BUS_READ: begin
        // empty tx ring gives zero and leaves the tail alone
        if (tx_tail_r != tx_head_r) begin
          result.data_out = tx_store_r[tx_tail_r];
          tx_tail_nxt     = tx_tail_inc;
        end
      end
      i2cbf_pkg::MODE_BUS_WRITE: begin
        rx_wr       = 1'b1;
        rx_head_nxt = rx_head_inc;
      end
      i2cbf_pkg::MODE_HOST_PUSH: begin
        tx_wr       = 1'b1;
        tx_head_nxt = tx_head_inc;
      end
      i2cbf_pkg::MODE_HOST_POP: begin
        // no empty check: stale byte comes out and tail moves on
        result.data_out = rx_store_r[rx_tail_r];
        rx_tail_nxt     = rx_tail_inc;
      end
      i2cbf_pkg::MODE_FLUSH: begin
        if (item.flush_rx) begin
          rx_head_nxt = '0;
          rx_tail_nxt = '0;
        end
        if (item.flush_tx) begin
          tx_head_nxt = '0;
          tx_tail_nxt = '0;
        end
      end
      default: begin
      end
    endcase
    // fill level after the event, modulo depth
    rx_fill = (rx_head_nxt >= rx_tail_nxt)
            ? {1'b0, rx_head_nxt} - {1'b0, rx_tail_nxt}
            : {1'b0, rx_head_nxt} + RX_DEPTH_X - {1'b0, rx_tail_nxt};
    result.rx_count = i2cbf_pkg::COUNT_W'(rx_fill);
    result.rx_empty = (rx_head_nxt == rx_tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
      for (int i = 0; i < i2cbf_pkg::RX_DEPTH; i++) rx_store_r[i] <= '0;
      for (int i = 0; i < i2cbf_pkg::TX_DEPTH; i++) tx_store_r[i] <= '0;
    end else if (fire) begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      if (rx_wr) rx_store_r[rx_head_r] <= item.data_in;
      if (tx_wr) tx_store_r[tx_head_r] <= item.data_in;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/i2c_target_byte_fifos_unit.sv -----
// i2c_target_byte_fifos_unit: top level, beat registers and address register
// uses i2cbf_pkg and i2cbf_core
`timescale 1ns / 1ps
`default_nettype none

//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid, in_stall, in_item    | one bus or host event per beat
//  out     | out_valid, out_stall, out_item | one result beat per event
//  cfg     | cfg_wr_en, cfg_wr_data         | own seven-bit address, write only
//
//  one event per cycle sustained while out_stall is low; a result passes from
//  the input register through the ring update into the result register, and
//  out_stall can hold it in either register
//  the rings are small flop arrays so each event reads or writes at most one entry
//  synchronous active-low reset clears the pointers, both rings and the address
//  out_stall holds the result register; the input register then holds and
//  in_stall rises only once that register is occupied and cannot drain

module i2c_target_byte_fifos_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire i2cbf_pkg::in_item_t           in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output i2cbf_pkg::out_item_t               out_item,
  input  wire logic                          cfg_wr_en,
  input  wire logic [i2cbf_pkg::ADDR_W-1:0]  cfg_wr_data
);

  logic                          in_v_r, in_v_nxt;
  i2cbf_pkg::in_item_t           in_item_r;
  logic                          out_v_r, out_v_nxt;
  i2cbf_pkg::out_item_t          out_item_r;
  i2cbf_pkg::out_item_t          result;
  logic [i2cbf_pkg::ADDR_W-1:0]  own_addr_r;
  logic                          in_take;
  logic                          advance;

  // the held event moves on when the result slot is free or draining
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  i2cbf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .item        (in_item_r),
    .own_address (own_addr_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      own_addr_r <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_wr_en) own_addr_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_item;
    if (advance) out_item_r <= result;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
